// ===== rtl/evep_pkg.sv =====
// Shared types and constants of the energy voice activity endpointer.
`default_nettype none

package evep_pkg;

	localparam int ACC_W     = 43;
	localparam int FLEN_W    = 13;
	localparam int CNT_W     = 16;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_W     = ACC_W;
	localparam int QUEUE_DEPTH = 4;

	localparam logic [ACC_W-1:0] ACC_MAX = {ACC_W{1'b1}};
	localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

	localparam logic [FLEN_W-1:0] FRAME_LENGTH_RST = FLEN_W'(1600);
	localparam logic [ACC_W-1:0]  THRESHOLD_RST    = ACC_W'(171798692);
	localparam logic [CNT_W-1:0]  SILENCE_RST      = CNT_W'(15);
	localparam logic [CNT_W-1:0]  TIMEOUT_RST      = CNT_W'(100);

	typedef enum logic {
		OP_SAMPLE = 1'b0,
		OP_START  = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		CAUSE_NONE    = 2'd0,
		CAUSE_SILENCE = 2'd1,
		CAUSE_TIMEOUT = 2'd2
	} cause_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FRAME_LENGTH = 2'd0,
		REG_THRESHOLD    = 2'd1,
		REG_SILENCE      = 2'd2,
		REG_TIMEOUT      = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic [FLEN_W-1:0] frame_length;
		logic [ACC_W-1:0]  energy_sum_threshold;
		logic [CNT_W-1:0]  silence_frames;
		logic [CNT_W-1:0]  timeout_frames;
	} cfg_t;

	typedef struct packed {
		logic [ACC_W-1:0] frame_energy;
		logic             frame_speech;
		logic             keep_frame;
		logic [CNT_W-1:0] frame_number;
		logic             finished;
		cause_t           end_cause;
	} result_t;

endpackage

`default_nettype wire

// ===== rtl/energy_vad_endpointer_unit.sv =====
// Top level of the energy-threshold voice activity endpointer.
`default_nettype none

//  Channel   Direction  Handshake            Payload
//  ------    ---------  -------------------  ------------------------------------------
//  input     in         push / full          op, sample
//  result    out        empty / pop          frame_energy, frame_speech, keep_frame,
//                                            frame_number, finished, end_cause
//  config    in         cfg_wen (no wait)    cfg_index, cfg_data
//
//  Sustained rate is one item per clock while the result queue has room; set by the
//  single add-and-compare of the accumulate step in the back end.
//  A frame verdict reaches the result ports after its last sample is written into the
//  command queue and the back end then writes the verdict into the result queue.
//  Reset is asynchronous: it empties both queues, ends any capture and restores
//  the register defaults. There is no clearing pass.
//  Holding pop low fills the result queue, then the command queue, then full rises.

module energy_vad_endpointer_unit
	import evep_pkg::*;
#(
	parameter int SAMPLE_BITS = 16,
	parameter int MAX_FRAME   = 4096
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	// Input channel
	input  wire logic                   push,
	output logic                        full,
	input  wire logic                   op,
	input  wire logic [SAMPLE_BITS-1:0] sample,
	// Result channel
	output logic                        empty,
	input  wire logic                   pop,
	output logic [ACC_W-1:0]            frame_energy,
	output logic                        frame_speech,
	output logic                        keep_frame,
	output logic [CNT_W-1:0]            frame_number,
	output logic                        finished,
	output logic [1:0]                  end_cause,
	// Configuration port
	input  wire logic                   cfg_wen,
	input  wire logic [CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [CFG_W-1:0]       cfg_data
);

	localparam int CMD_W = 2*SAMPLE_BITS;
	localparam int RES_W = $bits(result_t);

	cfg_t             cfg_q;
	reg_idx_t         widx;

	logic             cmd_push;
	logic [CMD_W-1:0] cmd_wdata;
	logic             cmd_full;
	logic             cmd_pop;
	logic [CMD_W-1:0] cmd_rdata;
	logic             cmd_empty;

	logic             res_push;
	result_t          res_wdata;
	logic             res_full;
	logic [RES_W-1:0] res_rdata;
	result_t          res_head;

	// Configuration registers: write only when no item is in flight.
	assign widx = reg_idx_t'(cfg_index);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.frame_length         <= FRAME_LENGTH_RST;
			cfg_q.energy_sum_threshold <= THRESHOLD_RST;
			cfg_q.silence_frames       <= SILENCE_RST;
			cfg_q.timeout_frames       <= TIMEOUT_RST;
		end else if (cfg_wen) begin
			unique case (widx)
				REG_FRAME_LENGTH: cfg_q.frame_length         <= cfg_data[FLEN_W-1:0];
				REG_THRESHOLD:    cfg_q.energy_sum_threshold <= cfg_data[ACC_W-1:0];
				REG_SILENCE:      cfg_q.silence_frames       <= cfg_data[CNT_W-1:0];
				REG_TIMEOUT:      cfg_q.timeout_frames       <= cfg_data[CNT_W-1:0];
			endcase
		end
	end

	// Front end: classify and square, then transfer into the command queue.
	evep_front #(
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_front (
		.push     (push),
		.op       (op),
		.sample   (sample),
		.cmd_full (cmd_full),
		.cmd_push (cmd_push),
		.cmd_data (cmd_wdata)
	);

	assign full = cmd_full;

	// Command queue decouples the front end from the back end.
	evep_fifo #(
		.WIDTH(CMD_W),
		.DEPTH(QUEUE_DEPTH)
	) u_cmd_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (cmd_push),
		.wdata  (cmd_wdata),
		.full   (cmd_full),
		.pop    (cmd_pop),
		.rdata  (cmd_rdata),
		.empty  (cmd_empty)
	);

	// Back end: accumulate, judge the frame, update the capture state.
	evep_back #(
		.SAMPLE_BITS(SAMPLE_BITS),
		.MAX_FRAME  (MAX_FRAME)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.cmd_empty (cmd_empty),
		.cmd_data  (cmd_rdata),
		.cmd_pop   (cmd_pop),
		.res_full  (res_full),
		.res_push  (res_push),
		.res_data  (res_wdata)
	);

	// Result queue holds verdicts while the consumer stalls.
	evep_fifo #(
		.WIDTH(RES_W),
		.DEPTH(QUEUE_DEPTH)
	) u_res_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.wdata  (res_wdata),
		.full   (res_full),
		.pop    (pop),
		.rdata  (res_rdata),
		.empty  (empty)
	);

	assign res_head     = result_t'(res_rdata);
	assign frame_energy = res_head.frame_energy;
	assign frame_speech = res_head.frame_speech;
	assign keep_frame   = res_head.keep_frame;
	assign frame_number = res_head.frame_number;
	assign finished     = res_head.finished;
	assign end_cause    = res_head.end_cause;

	// A finishing frame, and only that, carries a cause.
	a_cause_matches_finish: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (finished == (end_cause != CAUSE_NONE)))
		else $error("end_cause disagrees with finished");

	// A speech frame is always kept.
	a_speech_kept: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && frame_speech) |-> keep_frame)
		else $error("speech frame not kept");

	// A transferred item lands in the command queue.
	a_cmd_lands: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !full) |=> !cmd_empty)
		else $error("accepted item missing from command queue");

	// The back end never pushes into a full result queue.
	a_no_res_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |-> !res_full)
		else $error("result pushed while result queue full");

endmodule

`default_nettype wire

// ===== rtl/evep_fifo.sv =====
// Small first-word-fall-through queue built from flops; DEPTH is a power of two.
`default_nettype none

module evep_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] wdata,
	output logic                  full,
	input  wire logic             pop,
	output logic [WIDTH-1:0]      rdata,
	output logic                  empty
);

	localparam int PTR_W = $clog2(DEPTH);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [PTR_W:0]   count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == (PTR_W+1)'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + (PTR_W+1)'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - (PTR_W+1)'(1);
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/evep_front.sv =====
// Front end: classify each incoming item and square its sample.
`default_nettype none

module evep_front
	import evep_pkg::*;
#(
	parameter int SAMPLE_BITS = 16
) (
	input  wire logic                     push,
	input  wire logic                     op,
	input  wire logic [SAMPLE_BITS-1:0]   sample,
	input  wire logic                     cmd_full,
	output logic                          cmd_push,
	output logic [2*SAMPLE_BITS-1:0]      cmd_data
);

	logic [SAMPLE_BITS-1:0]   mag;
	logic [2*SAMPLE_BITS-1:0] square;
	op_t                      kind;

	// Magnitude as unsigned; the most negative code maps to 2^(N-1).
	assign mag    = sample[SAMPLE_BITS-1] ? (~sample + SAMPLE_BITS'(1)) : sample;
	assign square = mag * mag;
	assign kind   = op_t'(op);

	assign cmd_push = push && !cmd_full;
	// Command word: kind on top, square below (its top bit is always zero).
	assign cmd_data = {kind, square[2*SAMPLE_BITS-2:0]};

endmodule

`default_nettype wire

// ===== rtl/evep_back.sv =====
// Back end: accumulate frame energy, judge frames and track the capture.
`default_nettype none

module evep_back
	import evep_pkg::*;
#(
	parameter int SAMPLE_BITS = 16,
	parameter int MAX_FRAME   = 4096
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire cfg_t                     cfg,
	input  wire logic                     cmd_empty,
	input  wire logic [2*SAMPLE_BITS-1:0] cmd_data,
	output logic                          cmd_pop,
	input  wire logic                     res_full,
	output logic                          res_push,
	output result_t                       res_data
);

	localparam int SQ_W  = 2*SAMPLE_BITS - 1;
	localparam int SUM_W = ((SQ_W > ACC_W) ? SQ_W : ACC_W) + 1;
	localparam int SIF_W = $clog2(MAX_FRAME);
	localparam int MXL_W = $clog2(MAX_FRAME + 1);
	localparam int LEN_W = (MXL_W > FLEN_W) ? MXL_W : FLEN_W;

	logic [ACC_W-1:0] acc_q;
	logic [SIF_W-1:0] sif_q;
	logic [CNT_W-1:0] frames_q;
	logic [CNT_W-1:0] silent_q;
	logic             seen_q;
	logic             capturing_q;

	op_t              kind;
	logic [SQ_W-1:0]  square;
	logic [SUM_W-1:0] sum;
	logic [ACC_W-1:0] acc_new;
	logic [LEN_W-1:0] len_raw;
	logic [LEN_W-1:0] eff_len;
	logic [LEN_W-1:0] cnt_inc;
	logic             frame_end;
	logic             speech;
	logic             seen_n;
	logic [CNT_W-1:0] silent_n;
	logic [CNT_W-1:0] frames_n;
	logic             fin_silence;
	logic             fin_timeout;
	cause_t           cause;
	logic             take_sample;

	assign kind   = op_t'(cmd_data[2*SAMPLE_BITS-1]);
	assign square = cmd_data[SQ_W-1:0];

	// Advance only when the result queue has room, whether or not a result comes.
	assign cmd_pop     = !cmd_empty && !res_full;
	assign take_sample = cmd_pop && (kind == OP_SAMPLE) && capturing_q;

	// Saturating accumulate.
	assign sum     = SUM_W'(acc_q) + SUM_W'(square);
	assign acc_new = (sum[SUM_W-1:ACC_W] != '0) ? ACC_MAX : sum[ACC_W-1:0];

	// Clamp frame length to 1..MAX_FRAME.
	assign len_raw = LEN_W'(cfg.frame_length);
	always_comb begin
		priority if (len_raw == '0) begin
			eff_len = LEN_W'(1);
		end else if (len_raw > LEN_W'(MAX_FRAME)) begin
			eff_len = LEN_W'(MAX_FRAME);
		end else begin
			eff_len = len_raw;
		end
	end

	assign cnt_inc   = LEN_W'(sif_q) + LEN_W'(1);
	assign frame_end = (cnt_inc >= eff_len);

	assign speech = (acc_new >= cfg.energy_sum_threshold);
	assign seen_n = seen_q || speech;

	always_comb begin
		priority if (speech) begin
			silent_n = '0;
		end else if (seen_q && (silent_q != CNT_MAX)) begin
			silent_n = silent_q + CNT_W'(1);
		end else begin
			silent_n = silent_q;
		end
	end

	assign frames_n    = (frames_q != CNT_MAX) ? (frames_q + CNT_W'(1)) : frames_q;
	assign fin_silence = seen_n && (silent_n >= cfg.silence_frames);
	assign fin_timeout = (frames_n >= cfg.timeout_frames);

	always_comb begin
		priority if (fin_silence) begin
			cause = CAUSE_SILENCE;
		end else if (fin_timeout) begin
			cause = CAUSE_TIMEOUT;
		end else begin
			cause = CAUSE_NONE;
		end
	end

	assign res_push = take_sample && frame_end;

	always_comb begin
		res_data.frame_energy = acc_new;
		res_data.frame_speech = speech;
		res_data.keep_frame   = seen_n;
		res_data.frame_number = frames_q;
		res_data.finished     = (cause != CAUSE_NONE);
		res_data.end_cause    = cause;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q       <= '0;
			sif_q       <= '0;
			frames_q    <= '0;
			silent_q    <= '0;
			seen_q      <= 1'b0;
			capturing_q <= 1'b0;
		end else if (cmd_pop && (kind == OP_START)) begin
			acc_q       <= '0;
			sif_q       <= '0;
			frames_q    <= '0;
			silent_q    <= '0;
			seen_q      <= 1'b0;
			capturing_q <= 1'b1;
		end else if (take_sample) begin
			if (frame_end) begin
				acc_q    <= '0;
				sif_q    <= '0;
				frames_q <= frames_n;
				silent_q <= silent_n;
				seen_q   <= seen_n;
				if (cause != CAUSE_NONE) begin
					capturing_q <= 1'b0;
				end
			end else begin
				acc_q <= acc_new;
				sif_q <= cnt_inc[SIF_W-1:0];
			end
		end
	end

endmodule

`default_nettype wire

// ===== verif/testbench.sv =====
// Self-checking testbench for the energy-threshold voice activity endpointer.
`timescale 1ns / 1ps

module testbench;
	import evep_pkg::*;

	localparam int SAMPLE_W       = 16;
	localparam int MAX_FRAME_LEN  = 4096;
	localparam int CLK_HALF       = 6;
	localparam int RESET_CYCLES   = 6;
	localparam int RX_HOLD_CYCLES = 120;
	localparam int STALL_LIMIT    = 4000;
	// Verdicts land after the last sample passes both queues; leave margin before register writes.
	localparam int SETTLE_CYCLES  = 6;
	localparam int FULL_FRAME_LEN = 32;

	localparam longint unsigned ACC_LIMIT = (64'd1 << ACC_W) - 64'd1;
	localparam int unsigned     CNT_LIMIT = 65535;
	localparam longint unsigned FULL_SCALE_THR = 64'(FULL_FRAME_LEN) << 30;

	typedef enum int {
		AMP_QUIET,
		AMP_LOUD,
		AMP_WIDE,
		AMP_NEAR
	} amp_t;

	// Predicts one verdict per finished frame and checks the verdicts in order.
	class frame_verdict_board;
		logic [FLEN_W-1:0] flen;
		logic [ACC_W-1:0]  thr;
		logic [CNT_W-1:0]  sil_limit;
		logic [CNT_W-1:0]  tmo_limit;
		longint unsigned   energy;
		int unsigned       fill;
		int unsigned       frames;
		int unsigned       silent;
		bit                seen;
		bit                active;
		result_t           verdict_q[$];
		int                errors;

		function new();
			flen      = 13'd1600;
			thr       = 43'd171798692;
			sil_limit = 16'd15;
			tmo_limit = 16'd100;
			clear_capture();
			active = 1'b0;
			errors = 0;
		endfunction

		function void clear_capture();
			energy = 0;
			fill   = 0;
			frames = 0;
			silent = 0;
			seen   = 1'b0;
		endfunction

		function void write_reg(reg_idx_t idx, logic [CFG_W-1:0] val);
			case (idx)
			REG_FRAME_LENGTH: flen = val[FLEN_W-1:0];
			REG_THRESHOLD:    thr = val[ACC_W-1:0];
			REG_SILENCE:      sil_limit = val[CNT_W-1:0];
			REG_TIMEOUT:      tmo_limit = val[CNT_W-1:0];
			default:          ;
			endcase
		endfunction

		function int pending();
			return verdict_q.size();
		endfunction

		function void note_sample(op_t kind, logic signed [SAMPLE_W-1:0] s);
			longint unsigned sq;
			int              mag;
			int unsigned     eff;
			int unsigned     number;
			bit              speech;
			cause_t          cause;
			result_t         v;
			if (kind == OP_START) begin
				clear_capture();
				active = 1'b1;
				return;
			end
			// Drop samples outside a capture.
			if (!active)
				return;
			mag = (s < 0) ? -int'(s) : int'(s);
			sq = longint'(mag) * longint'(mag);
			if (sq > ACC_LIMIT - energy)
				energy = ACC_LIMIT;
			else
				energy += sq;
			fill++;
			eff = (flen == 0) ? 1 : ((flen > MAX_FRAME_LEN) ? MAX_FRAME_LEN : flen);
			if (fill < eff)
				return;

			speech = (energy >= thr);
			if (speech) begin
				seen   = 1'b1;
				silent = 0;
			end else if (seen && silent < CNT_LIMIT) begin
				silent++;
			end
			number = frames;
			if (frames < CNT_LIMIT)
				frames++;
			// Silence takes priority over timeout on the same frame.
			if (seen && silent >= sil_limit)
				cause = CAUSE_SILENCE;
			else if (frames >= tmo_limit)
				cause = CAUSE_TIMEOUT;
			else
				cause = CAUSE_NONE;

			v.frame_energy = ACC_W'(energy);
			v.frame_speech = speech;
			v.keep_frame   = seen;
			v.frame_number = CNT_W'(number);
			v.finished     = (cause != CAUSE_NONE);
			v.end_cause    = cause;
			verdict_q.push_back(v);

			energy = 0;
			fill   = 0;
			if (cause != CAUSE_NONE)
				active = 1'b0;
		endfunction

		function void check_field(string name, logic [63:0] want, logic [63:0] got);
			if (want !== got) begin
				$error("%s: expected %0d, actual %0d", name, want, got);
				errors++;
			end
		endfunction

		function void check_verdict(result_t got);
			result_t want;
			if (verdict_q.size() == 0) begin
				$error("frame verdict transferred with no frame pending");
				errors++;
				return;
			end
			want = verdict_q.pop_front();
			check_field("frame_energy", 64'(want.frame_energy), 64'(got.frame_energy));
			check_field("frame_speech", 64'(want.frame_speech), 64'(got.frame_speech));
			check_field("keep_frame", 64'(want.keep_frame), 64'(got.keep_frame));
			check_field("frame_number", 64'(want.frame_number), 64'(got.frame_number));
			check_field("finished", 64'(want.finished), 64'(got.finished));
			check_field("end_cause", 64'(want.end_cause), 64'(got.end_cause));
		endfunction
	endclass

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 push      = 1'b0;
	logic                 full;
	logic                 op        = 1'b0;
	logic [SAMPLE_W-1:0]  sample    = '0;
	logic                 empty;
	logic                 pop       = 1'b0;
	logic [ACC_W-1:0]     frame_energy;
	logic                 frame_speech;
	logic                 keep_frame;
	logic [CNT_W-1:0]     frame_number;
	logic                 finished;
	logic [1:0]           end_cause;
	logic                 cfg_wen   = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0]     cfg_data  = '0;

	// Idling controls shared between the sender, the receiver and the phase sequence.
	bit tx_idle     = 1'b0;
	bit rx_idle     = 1'b0;
	bit rx_hold_req = 1'b0;
	int level       = 6000;

	frame_verdict_board verdicts = new();

	energy_vad_endpointer_unit #(
		.SAMPLE_BITS(SAMPLE_W),
		.MAX_FRAME(MAX_FRAME_LEN)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.op(op),
		.sample(sample),
		.empty(empty),
		.pop(pop),
		.frame_energy(frame_energy),
		.frame_speech(frame_speech),
		.keep_frame(keep_frame),
		.frame_number(frame_number),
		.finished(finished),
		.end_cause(end_cause),
		.cfg_wen(cfg_wen),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		forever #CLK_HALF clk = ~clk;
	end

	// Hold reset at the start, then release it for good.
	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
	end

	// Input monitor: every transfer into the block feeds the predictor.
	always @(posedge clk) begin
		if (arst_n && push && !full)
			verdicts.note_sample(op_t'(op), $signed(sample));
	end

	// Result monitor: every transfer out of the block is checked against the oldest verdict.
	always @(posedge clk) begin : result_monitor
		result_t got;
		if (arst_n && pop && !empty) begin
			got.frame_energy = frame_energy;
			got.frame_speech = frame_speech;
			got.keep_frame   = keep_frame;
			got.frame_number = frame_number;
			got.finished     = finished;
			got.end_cause    = cause_t'(end_cause);
			verdicts.check_verdict(got);
		end
	end

	// Watchdog: end the run when no transfer happens on either side for too long.
	always @(posedge clk) begin : watchdog
		int stall_cnt;
		if (arst_n) begin
			if ((push && !full) || (pop && !empty))
				stall_cnt = 0;
			else
				stall_cnt++;
			if (stall_cnt >= STALL_LIMIT) begin
				$display("TB_ERROR");
				$finish;
			end
		end
	end

	// Receiver: draw a gap per verdict; on request, hold off long enough to back up the input.
	initial begin : result_drain
		int gap;
		wait (arst_n === 1'b1);
		forever begin
			gap = rx_idle ? $urandom_range(0, 8) : 0;
			if (rx_hold_req) begin
				rx_hold_req = 1'b0;
				gap = RX_HOLD_CYCLES;
			end
			if (gap != 0) begin
				pop <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			pop <= 1'b1;
			@(posedge clk);
			while (empty) @(posedge clk);
		end
	end

	// Offer one item and hold it until the block takes it.
	task automatic send_item(op_t kind, logic signed [SAMPLE_W-1:0] value);
		int gap;
		gap = tx_idle ? $urandom_range(0, 8) : 0;
		if (gap != 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push   <= 1'b1;
		op     <= kind;
		sample <= value;
		@(posedge clk);
		while (full) @(posedge clk);
	endtask

	// Stop offering and wait until every predicted verdict has been transferred out.
	task automatic wait_idle();
		push <= 1'b0;
		@(posedge clk);
		while (verdicts.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Write all four registers back to back; unused upper data bits carry noise.
	task automatic configure(int unsigned flen, longint unsigned thr, int unsigned sil,
			int unsigned tmo);
		reg_idx_t         idx [4];
		logic [CFG_W-1:0] val [4];
		wait_idle();
		idx[0] = REG_FRAME_LENGTH;
		idx[1] = REG_THRESHOLD;
		idx[2] = REG_SILENCE;
		idx[3] = REG_TIMEOUT;
		val[0] = {30'($urandom), FLEN_W'(flen)};
		val[1] = CFG_W'(thr);
		val[2] = {27'($urandom), CNT_W'(sil)};
		val[3] = {27'($urandom), CNT_W'(tmo)};
		for (int i = 0; i < 4; i++) begin
			cfg_wen   <= 1'b1;
			cfg_index <= idx[i];
			cfg_data  <= val[i];
			@(posedge clk);
			verdicts.write_reg(idx[i], val[i]);
		end
		cfg_wen <= 1'b0;
	endtask

	// Pick a threshold that puts speech at an RMS level around the chosen amplitude.
	function automatic longint unsigned speech_threshold(int unsigned flen);
		level = $urandom_range(2000, 12000);
		return longint'(flen) * longint'(level) * longint'(level);
	endfunction

	function automatic logic signed [SAMPLE_W-1:0] pick_sample(amp_t amp);
		int mag;
		case (amp)
		AMP_QUIET: mag = $urandom_range(0, 300);
		AMP_LOUD:  mag = $urandom_range(12000, 32767);
		AMP_NEAR:  mag = $urandom_range(level - level / 8, level + level / 8);
		default:   return SAMPLE_W'($urandom);
		endcase
		return SAMPLE_W'($urandom_range(0, 1) ? -mag : mag);
	endfunction

	// Mostly well-formed captures: a start, then runs of quiet, loud, near-level or random
	// samples. Stray samples between captures and restarts mid-capture make up the noise.
	task automatic random_phase(int unsigned n);
		int unsigned done;
		amp_t        amp;
		bit          live;
		done = 0;
		amp  = AMP_WIDE;
		while (done < n) begin
			if ($urandom_range(0, 7) == 0)
				amp = amp_t'($urandom_range(0, 3));
			live = verdicts.active;
			if ((!live && $urandom_range(0, 9) != 0) || $urandom_range(0, 99) == 0) begin
				send_item(OP_START, SAMPLE_W'($urandom));
				done++;
			end else begin
				send_item(OP_SAMPLE, pick_sample(amp));
				if (live)
					done++;
			end
		end
	endtask

	task automatic phase(int unsigned flen, longint unsigned thr, int unsigned sil,
			int unsigned tmo, int unsigned n, bit txi, bit rxi);
		configure(flen, thr, sil, tmo);
		tx_idle = txi;
		rx_idle = rxi;
		// Open a fresh capture so no partial frame spans the register change.
		send_item(OP_START, SAMPLE_W'($urandom));
		random_phase(n);
	endtask

	initial begin : stimulus
		wait (arst_n === 1'b1);
		@(posedge clk);

		// Reset settings: a sample before any start is dropped, then a partial default frame
		// that the next start discards.
		send_item(OP_SAMPLE, 16'sh7fff);
		send_item(OP_START, '0);
		repeat (40) send_item(OP_SAMPLE, SAMPLE_W'($urandom));

		// Two-sample frames: loud extremes, then silence ends the capture.
		configure(2, 64'd2000000, 1, 3);
		send_item(OP_START, '0);
		send_item(OP_SAMPLE, 16'sh7fff);
		send_item(OP_SAMPLE, 16'sh8000);
		send_item(OP_SAMPLE, '0);
		send_item(OP_SAMPLE, '0);
		send_item(OP_SAMPLE, 16'sd5);
		// Never speech: the third frame hits the timeout.
		send_item(OP_START, '0);
		send_item(OP_SAMPLE, '0);
		send_item(OP_SAMPLE, '0);
		send_item(OP_SAMPLE, 16'sd1);
		send_item(OP_SAMPLE, -16'sd1);
		send_item(OP_SAMPLE, 16'sd100);
		send_item(OP_SAMPLE, -16'sd100);
		// Restart in the middle of a capture.
		send_item(OP_START, '0);
		send_item(OP_SAMPLE, 16'sh7fff);
		send_item(OP_SAMPLE, 16'sh7fff);
		send_item(OP_START, '0);
		send_item(OP_SAMPLE, -16'sd1);
		send_item(OP_SAMPLE, -16'sd2);

		// Frame length zero acts as one; zero silence and zero timeout end on the first frame.
		configure(0, 64'd1000, 0, 0);
		send_item(OP_START, '0);
		send_item(OP_SAMPLE, 16'sd20000);
		send_item(OP_START, '0);
		send_item(OP_SAMPLE, 16'sd5);

		// Silence and timeout on the same frame: silence wins.
		configure(1, 64'd1000, 1, 2);
		send_item(OP_START, '0);
		send_item(OP_SAMPLE, 16'sd20000);
		send_item(OP_SAMPLE, '0);

		phase(1, speech_threshold(1), 2, 40, 120, 1'b1, 1'b1);
		phase(3, 64'd0, 0, 65535, 60, 1'b1, 1'b1);
		phase(4, ACC_LIMIT, 65535, 5, 60, 1'b1, 1'b0);
		phase(5, speech_threshold(5), 3, 12, 120, 1'b1, 1'b0);
		phase(2, speech_threshold(2), 1, 8, 100, 1'b0, 1'b1);
		phase(6, speech_threshold(6), 2, 1, 80, 1'b0, 1'b0);

		// Back-pressure: the receiver holds off while the sender keeps offering one-sample frames.
		configure(1, speech_threshold(1), 4, 30);
		tx_idle = 1'b0;
		rx_idle = 1'b1;
		rx_hold_req = 1'b1;
		send_item(OP_START, '0);
		random_phase(60);

		phase(16, speech_threshold(16), 5, 20, 100, 1'b1, 1'b1);

		// Full-scale positive samples stay just below the threshold; full-scale negative
		// samples land exactly on it, and the second frame is speech and times out.
		configure(FULL_FRAME_LEN, FULL_SCALE_THR, 65535, 2);
		tx_idle = 1'b0;
		rx_idle = 1'b1;
		send_item(OP_START, '0);
		repeat (FULL_FRAME_LEN) send_item(OP_SAMPLE, 16'sh7fff);
		send_item(OP_START, '0);
		repeat (FULL_FRAME_LEN) send_item(OP_SAMPLE, SAMPLE_W'($urandom));
		repeat (FULL_FRAME_LEN) send_item(OP_SAMPLE, 16'sh8000);

		wait_idle();
		if (verdicts.errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/evep_pkg.sv
rtl/evep_fifo.sv
rtl/evep_front.sv
rtl/evep_back.sv
rtl/energy_vad_endpointer_unit.sv
verif/testbench.sv
